// ===== sv/serial_line_editor_macros.svh =====
// ----------------------------------------------------------------------------
// Serial line editor assertion macros
// Short forms for the concurrent checks at the end of the top level. Each
// expects signals named clk and rst in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef SERIAL_LINE_EDITOR_MACROS_SVH
`define SERIAL_LINE_EDITOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sle_pkg.sv =====
// ----------------------------------------------------------------------------
// Serial line editor package
// Field widths, request and result codes, character codes and defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package sle_pkg;

  localparam int REQ_W  = 2;
  localparam int BYTE_W = 8;
  localparam int KIND_W = 2;

  localparam int LINE_DEPTH_DEF = 256;

  // Request codes; the fourth code carries no meaning and is ignored.
  localparam logic [REQ_W-1:0] REQ_RX      = 2'd0;
  localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ    = 2'd2;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_ECHO   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;

  // Character codes.
  localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_SP  = 8'h20;
  localparam logic [BYTE_W-1:0] CH_BS  = 8'h08;
  localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;

  // Work held by the result engine for one item.
  typedef enum logic [2:0] {
    OP_READ,
    OP_REJECT,
    OP_CRLF,
    OP_CLEAR,
    OP_ECHO,
    OP_STORE,
    OP_ERASE
  } op_t;

endpackage

`default_nettype wire

// ===== sv/sle_req_if.sv =====
// ----------------------------------------------------------------------------
// Serial line editor request channel
// Valid/ready channel carrying one request item.
// ----------------------------------------------------------------------------
`default_nettype none

interface sle_req_if;
  import sle_pkg::*;

  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [BYTE_W-1:0] rx_byte;
  logic [BYTE_W-1:0] read_index;

  modport source (output valid, output req_type, output rx_byte, output read_index,
                  input ready);
  modport sink   (input valid, input req_type, input rx_byte, input read_index,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/sle_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Serial line editor result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface sle_rsp_if;
  import sle_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] result_kind;
  logic [BYTE_W-1:0] data_byte;
  logic              line_ready;
  logic [BYTE_W-1:0] line_length;
  logic              last;

  modport source (output valid, output result_kind, output data_byte,
                  output line_ready, output line_length, output last, input ready);
  modport sink   (input valid, input result_kind, input data_byte,
                  input line_ready, input line_length, input last, output ready);
endinterface

`default_nettype wire

// ===== sv/serial_line_editor.sv =====
// ----------------------------------------------------------------------------
// Serial line editor
// Builds a command line from received bytes in a line store memory and
// produces the echo, read and reject result items.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Moves
//   req      in         one request item: receive byte, release line, read byte
//   rsp      out        one result item: echo byte, read data or rejected byte
//
// An item that produces results gives one result per engine step, and a
// stored printable byte needs a further step for its zero terminator, since
// the store has a single write port and writes the byte and the terminator
// in turn. Release, unused requests and a backspace on an empty line finish at
// acceptance and never enter the engine.
// After reset the line store is swept to zero, one entry per cycle, from the
// first entry to the last; no item is accepted during the sweep.
// A stalled result channel holds the engine at its next result; the output
// register lets the engine run one result ahead of the consumer.
`default_nettype none

`include "serial_line_editor_macros.svh"

module serial_line_editor #(
  parameter int LINE_DEPTH = sle_pkg::LINE_DEPTH_DEF
) (
  input  wire         clk,
  input  wire         rst,
  sle_req_if.sink     req,
  sle_rsp_if.source   rsp
);
  import sle_pkg::*;

  // Address width of the line store, and the highest fill the line may reach
  // (one entry is always kept for the zero terminator).
  localparam int              AW        = (LINE_DEPTH > 2) ? $clog2(LINE_DEPTH) : 1;
  localparam logic [AW-1:0]   ADDR_LAST = AW'(LINE_DEPTH - 1);
  localparam logic [AW-1:0]   FILL_MAX  = AW'(LINE_DEPTH - 1);

  // Line store memory, one write and one registered read port.
  logic [BYTE_W-1:0] line_store [LINE_DEPTH];
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [BYTE_W-1:0] mem_wd;
  logic [AW-1:0]     mem_ra;
  logic [BYTE_W-1:0] mem_q;

  // Reset sweep.
  logic          clearing;
  logic [AW-1:0] clr_addr;

  // Line state.
  logic [AW-1:0] fill_count;
  logic [AW-1:0] fill_count_next;
  logic          locked;
  logic          locked_next;

  // Engine registers for the item in progress.
  logic              cur_valid;
  op_t               cur_op;
  logic [BYTE_W-1:0] cur_ch;
  logic [AW-1:0]     cur_base;
  logic [1:0]        step;

  // Read data bypass and out-of-range flag, captured with the read.
  logic              fwd_hit;
  logic [BYTE_W-1:0] fwd_data;
  logic              rd_zero;
  logic [BYTE_W-1:0] rd_byte;

  // Decoded request.
  logic          in_fire;
  logic          in_work;
  op_t           in_op;
  logic [AW-1:0] in_base;
  logic          rx_print;

  // Engine step outputs.
  logic              st_emit;
  logic [KIND_W-1:0] st_kind;
  logic [BYTE_W-1:0] st_data;
  logic              st_last;
  logic              st_done;
  logic              st_we;
  logic [AW-1:0]     st_wa;
  logic [BYTE_W-1:0] st_wd;
  logic              step_go;
  logic              out_free;

  // Output register.
  logic              out_valid;
  logic [KIND_W-1:0] out_kind;
  logic [BYTE_W-1:0] out_data;
  logic              out_line_ready;
  logic [BYTE_W-1:0] out_line_length;
  logic              out_last;
  logic [BYTE_W-1:0] len_now;

  // --------------------------------------------------------------------------
  // Handshake. A new item enters when the engine is empty or finishing.
  // --------------------------------------------------------------------------
  assign out_free  = !out_valid || rsp.ready;
  assign step_go   = cur_valid && (!st_emit || out_free);
  assign req.ready = !clearing && (!cur_valid || (step_go && st_done));
  assign in_fire   = req.valid && req.ready;

  assign rx_print = (req.rx_byte >= CH_SP);

  // Decode the request against the current line state. The line state is
  // updated at acceptance so that every result of the item reports the state
  // left by the item.
  always_comb begin
    in_work         = 1'b0;
    in_op           = OP_ECHO;
    in_base         = fill_count;
    fill_count_next = fill_count;
    locked_next     = locked;
    case (req.req_type)
      REQ_RELEASE: begin
        fill_count_next = '0;
        locked_next     = 1'b0;
      end
      REQ_READ: begin
        in_work = 1'b1;
        in_op   = OP_READ;
      end
      REQ_RX: begin
        in_work = 1'b1;
        if (locked) begin
          in_op = OP_REJECT;
        end else if (req.rx_byte == CH_CR) begin
          in_op       = OP_CRLF;
          locked_next = 1'b1;
        end else if (rx_print) begin
          if (fill_count < FILL_MAX) begin
            in_op           = OP_STORE;
            fill_count_next = fill_count + 1'b1;
          end else begin
            in_op = OP_ECHO;
          end
        end else if (req.rx_byte == CH_BS) begin
          // Backspace on an empty line does nothing at all.
          if (fill_count != '0) begin
            in_op           = OP_ERASE;
            in_base         = fill_count - 1'b1;
            fill_count_next = fill_count - 1'b1;
          end else begin
            in_work = 1'b0;
          end
        end else begin
          in_op           = OP_CLEAR;
          fill_count_next = '0;
          locked_next     = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      locked     <= 1'b0;
    end else if (in_fire) begin
      fill_count <= fill_count_next;
      locked     <= locked_next;
    end
  end

  // --------------------------------------------------------------------------
  // Reset sweep of the line store.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == ADDR_LAST) begin
        clearing <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Line store. The read is taken at acceptance of the item; a write landing
  // on the same entry at that same edge is forwarded in place of the old data.
  // --------------------------------------------------------------------------
  assign mem_we = clearing || (step_go && st_we);
  assign mem_wa = clearing ? clr_addr : st_wa;
  assign mem_wd = clearing ? CH_NUL : st_wd;
  assign mem_ra = AW'(req.read_index);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_store[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mem_q    <= line_store[mem_ra];
      fwd_hit  <= mem_we && (mem_wa == mem_ra);
      fwd_data <= mem_wd;
      rd_zero  <= !(32'(req.read_index) < 32'(LINE_DEPTH));
    end
  end

  assign rd_byte = rd_zero ? CH_NUL : (fwd_hit ? fwd_data : mem_q);

  // --------------------------------------------------------------------------
  // Result engine: one step per cycle unless a stalled result channel holds
  // it, each step giving at most one result and at most one store write.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      step      <= '0;
    end else if (in_fire && in_work) begin
      cur_valid <= 1'b1;
      step      <= '0;
    end else if (step_go && st_done) begin
      cur_valid <= 1'b0;
      step      <= '0;
    end else if (step_go) begin
      step <= step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_work) begin
      cur_op   <= in_op;
      cur_ch   <= req.rx_byte;
      cur_base <= in_base;
    end
  end

  always_comb begin
    st_emit = 1'b1;
    st_kind = KIND_ECHO;
    st_data = cur_ch;
    st_last = 1'b1;
    st_done = 1'b1;
    st_we   = 1'b0;
    st_wa   = cur_base;
    st_wd   = CH_NUL;
    case (cur_op)
      OP_READ: begin
        st_kind = KIND_READ;
        st_data = rd_byte;
      end
      OP_REJECT: begin
        st_kind = KIND_REJECT;
      end
      OP_ECHO: begin
      end
      OP_CRLF, OP_CLEAR: begin
        // The discarding form also zeroes the first entry with its CR.
        if (step == 2'd0) begin
          st_data = CH_CR;
          st_last = 1'b0;
          st_done = 1'b0;
          st_we   = (cur_op == OP_CLEAR);
          st_wa   = '0;
        end else begin
          st_data = CH_LF;
        end
      end
      OP_STORE: begin
        // Byte and echo first, then the terminator one entry further on.
        if (step == 2'd0) begin
          st_done = 1'b0;
          st_we   = 1'b1;
          st_wd   = cur_ch;
        end else begin
          st_emit = 1'b0;
          st_we   = 1'b1;
          st_wa   = cur_base + 1'b1;
        end
      end
      OP_ERASE: begin
        st_last = (step == 2'd2);
        st_done = (step == 2'd2);
        st_data = (step == 2'd1) ? CH_SP : CH_BS;
        st_we   = (step == 2'd0);
      end
      default: begin
        st_emit = 1'b0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Output register.
  // --------------------------------------------------------------------------
  assign len_now = (32'(fill_count) > 32'd255) ? 8'hFF : 8'(fill_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_go && st_emit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go && st_emit) begin
      out_kind        <= st_kind;
      out_data        <= st_data;
      out_line_ready  <= locked;
      out_line_length <= len_now;
      out_last        <= st_last;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.result_kind = out_kind;
  assign rsp.data_byte   = out_data;
  assign rsp.line_ready  = out_line_ready;
  assign rsp.line_length = out_line_length;
  assign rsp.last        = out_last;

  // --------------------------------------------------------------------------
  // Checks.
  // --------------------------------------------------------------------------
  `SLE_ASSERT_NOW(a_fill_range, 1'b1, fill_count <= FILL_MAX, "fill count beyond line")
  `SLE_ASSERT_NOW(a_quiet_clear, clearing, !rsp.valid && !cur_valid, "activity in sweep")
  `SLE_ASSERT_NOW(a_reject_locked, rsp.valid && (rsp.result_kind == KIND_REJECT),
                  rsp.line_ready, "reject while unlocked")
  `SLE_ASSERT_NEXT(a_release, in_fire && (req.req_type == REQ_RELEASE),
                   !locked && (fill_count == '0), "release left line held")

endmodule

`default_nettype wire

// ===== bench/tb_serial_line_editor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial line editor testbench
// Drives request items into the line editor and checks every result item. A
// scoreboard keeps its own copy of the line store, the fill count and the
// lock flag, and works out the echo, read and reject results of each accepted
// request. A directed opening is followed by one full-line run and by random
// command lines and noise, under four patterns of source idling and sink
// stalling.
// ----------------------------------------------------------------------------

// One result item as seen on the result channel.
typedef struct packed {
  logic [sle_pkg::KIND_W-1:0] kind;
  logic [sle_pkg::BYTE_W-1:0] data;
  logic                       line_ready;
  logic [sle_pkg::BYTE_W-1:0] line_len;
  logic                       last;
} line_result_t;

// Tracks the editor's line and the results it still owes.
class line_scoreboard;
  logic [sle_pkg::BYTE_W-1:0] store [sle_pkg::LINE_DEPTH_DEF];
  int unsigned                fill;
  bit                         locked;
  line_result_t               awaited[$];
  int unsigned                errors;

  function new();
    foreach (store[i]) store[i] = '0;
    fill   = 0;
    locked = 1'b0;
    errors = 0;
  endfunction

  // Line state is taken after the request has changed it.
  function void queue_result(input logic [sle_pkg::KIND_W-1:0] kind,
                             input logic [sle_pkg::BYTE_W-1:0] data);
    line_result_t r;
    r.kind       = kind;
    r.data       = data;
    r.line_ready = locked;
    r.line_len   = fill[sle_pkg::BYTE_W-1:0];
    r.last       = 1'b0;
    awaited.push_back(r);
  endfunction

  function void note_request(input logic [sle_pkg::REQ_W-1:0]  req_type,
                             input logic [sle_pkg::BYTE_W-1:0] ch,
                             input logic [sle_pkg::BYTE_W-1:0] index);
    int unsigned start;
    start = awaited.size();
    case (req_type)
      sle_pkg::REQ_RELEASE: begin
        locked = 1'b0;
        fill   = 0;
      end
      sle_pkg::REQ_READ: queue_result(sle_pkg::KIND_READ, store[index]);
      sle_pkg::REQ_RX: begin
        if (locked) begin
          queue_result(sle_pkg::KIND_REJECT, ch);
        end else if (ch == sle_pkg::CH_CR) begin
          locked = 1'b1;
          queue_result(sle_pkg::KIND_ECHO, sle_pkg::CH_CR);
          queue_result(sle_pkg::KIND_ECHO, sle_pkg::CH_LF);
        end else if (ch >= sle_pkg::CH_SP) begin
          if (fill < sle_pkg::LINE_DEPTH_DEF - 1) begin
            store[fill] = ch;
            fill++;
            store[fill] = sle_pkg::CH_NUL;
          end
          queue_result(sle_pkg::KIND_ECHO, ch);
        end else if (ch == sle_pkg::CH_BS) begin
          if (fill > 0) begin
            fill--;
            store[fill] = sle_pkg::CH_NUL;
            queue_result(sle_pkg::KIND_ECHO, sle_pkg::CH_BS);
            queue_result(sle_pkg::KIND_ECHO, sle_pkg::CH_SP);
            queue_result(sle_pkg::KIND_ECHO, sle_pkg::CH_BS);
          end
        end else begin
          store[0] = sle_pkg::CH_NUL;
          fill     = 0;
          locked   = 1'b1;
          queue_result(sle_pkg::KIND_ECHO, sle_pkg::CH_CR);
          queue_result(sle_pkg::KIND_ECHO, sle_pkg::CH_LF);
        end
      end
      default: ;
    endcase
    if (awaited.size() > start) awaited[awaited.size()-1].last = 1'b1;
  endfunction

  function void mismatch(input string field, input logic [7:0] want_v,
                         input logic [7:0] got_v);
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want_v, got_v);
    errors++;
  endfunction

  function void check_result(input line_result_t got);
    line_result_t want;
    if (awaited.size() == 0) begin
      $display("%0t: unexpected result, kind %h data %h", $time, got.kind, got.data);
      errors++;
      return;
    end
    want = awaited.pop_front();
    if (got.kind !== want.kind)             mismatch("result_kind", 8'(want.kind),
                                                     8'(got.kind));
    if (got.data !== want.data)             mismatch("data_byte", want.data, got.data);
    if (got.line_ready !== want.line_ready) mismatch("line_ready", 8'(want.line_ready),
                                                     8'(got.line_ready));
    if (got.line_len !== want.line_len)     mismatch("line_length", want.line_len,
                                                     got.line_len);
    if (got.last !== want.last)             mismatch("last", 8'(want.last), 8'(got.last));
  endfunction
endclass

module tb_serial_line_editor;
  import sle_pkg::*;

  // The fourth request code has no meaning; the editor must ignore it.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  // Cycles without any accepted item before the run is declared hung. The
  // clearing sweep after reset ends well inside this.
  localparam int WATCHDOG_LIMIT = 4000;
  // Quiet cycles allowed at the very end for any stray result to show up.
  localparam int DRAIN_CYCLES   = 8;
  // Random request items per idling phase.
  localparam int PHASE_ITEMS    = 36;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sle_req_if req ();
  sle_rsp_if rsp ();

  serial_line_editor dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  line_scoreboard line_sb = new();

  // Percentages of cycles in which the source holds back and the sink stalls.
  int unsigned src_idle_pct  = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned items_sent    = 0;
  int unsigned quiet_cycles  = 0;
  line_result_t seen;

  // Result side. Everything here runs at the rising edge, before any
  // nonblocking update of that edge, so the sampled values are the ones the
  // editor presented during the cycle just ended.
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      seen.kind       = rsp.result_kind;
      seen.data       = rsp.data_byte;
      seen.line_ready = rsp.line_ready;
      seen.line_len   = rsp.line_length;
      seen.last       = rsp.last;
      line_sb.check_result(seen);
    end
    rsp.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // Watchdog: a long stretch with no item moving on either channel means the
  // editor has hung, whatever the reason.
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no item accepted for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("FAIL serial_line_editor");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Presents one request item and holds it until it is accepted. It is called
  // at a rising edge, and returns at the edge of acceptance so that the next
  // item can follow back to back with valid left high.
  task automatic send_item(input logic [REQ_W-1:0]  req_type,
                           input logic [BYTE_W-1:0] ch,
                           input logic [BYTE_W-1:0] index);
    while ($urandom_range(99) < src_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid      <= 1'b1;
    req.req_type   <= req_type;
    req.rx_byte    <= ch;
    req.read_index <= index;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    line_sb.note_request(req_type, ch, index);
    items_sent++;
  endtask

  // Holds the source back until every owed result has come out. Always
  // advances at least one edge so valid is never lowered and raised in the
  // same step.
  task automatic wait_drained();
    req.valid <= 1'b0;
    do @(posedge clk); while (line_sb.awaited.size() != 0);
  endtask

  // Types a line longer than the store holds: the bytes past the room are
  // echoed but dropped, and the last entry keeps the terminator.
  task automatic fill_whole_line();
    send_item(REQ_RELEASE, 8'h00, 8'h00);
    repeat (LINE_DEPTH_DEF + 4) send_item(REQ_RX, 8'($urandom_range(8'h20, 8'hFF)), 8'h00);
    send_item(REQ_READ, 8'h00, 8'd254);
    send_item(REQ_READ, 8'h00, 8'd255);
    send_item(REQ_RX, CH_BS, 8'h00);
    send_item(REQ_READ, 8'h00, 8'd253);
    send_item(REQ_READ, 8'h00, 8'd254);
    send_item(REQ_RX, CH_CR, 8'h00);
    send_item(REQ_RELEASE, 8'h00, 8'h00);
  endtask

  // Mostly well-formed command lines: release, typed bytes with the odd
  // backspace, then carriage return or a stray control byte, a few refused
  // bytes while locked and some reads of the finished line. The rest is
  // noise with every field random.
  task automatic random_traffic(input int unsigned budget);
    int unsigned stop_at;
    int unsigned line_len;
    logic [BYTE_W-1:0] ctrl;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      if ($urandom_range(9) < 7) begin
        send_item(REQ_RELEASE, 8'($urandom), 8'($urandom));
        line_len = $urandom_range(0, 12);
        for (int unsigned j = 0; j < line_len; j++) begin
          if (j > 0 && $urandom_range(7) == 0)
            send_item(REQ_RX, CH_BS, 8'($urandom));
          else
            send_item(REQ_RX, 8'($urandom_range(8'h20, 8'hFF)), 8'($urandom));
        end
        if ($urandom_range(5) == 0) begin
          // Any byte below space other than backspace ends the line, CR
          // among them.
          ctrl = 8'($urandom_range(8'h00, 8'h1F));
          send_item(REQ_RX, ctrl, 8'($urandom));
        end else begin
          send_item(REQ_RX, CH_CR, 8'($urandom));
        end
        repeat ($urandom_range(0, 2)) send_item(REQ_RX, 8'($urandom), 8'($urandom));
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(3) == 0)
            send_item(REQ_READ, 8'($urandom), 8'($urandom));
          else
            send_item(REQ_READ, 8'($urandom), 8'($urandom_range(0, 15)));
        end
      end else begin
        repeat ($urandom_range(1, 4))
          send_item(2'($urandom), 8'($urandom), 8'($urandom));
      end
      // Now and then let the editor empty out completely before going on.
      if ($urandom_range(4) == 0) wait_drained();
    end
  endtask

  initial begin
    req.valid      = 1'b0;
    req.req_type   = REQ_RX;
    req.rx_byte    = 8'h00;
    req.read_index = 8'h00;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed opening, no idling. The store reads as zero after reset, and
    // a backspace on an empty line must produce nothing at all.
    send_item(REQ_READ, 8'h00, 8'h00);
    send_item(REQ_READ, 8'h00, 8'hFF);
    send_item(REQ_RX, CH_BS, 8'h00);
    // Printable bytes at both ends of the range, then erase the last one.
    send_item(REQ_RX, CH_SP, 8'h00);
    send_item(REQ_RX, 8'h7F, 8'h00);
    send_item(REQ_RX, 8'hFF, 8'h00);
    send_item(REQ_RX, 8'h41, 8'h00);
    send_item(REQ_RX, CH_BS, 8'h00);
    send_item(REQ_READ, 8'h00, 8'h02);
    send_item(REQ_READ, 8'h00, 8'h03);
    // Carriage return locks the line; bytes are then refused, reads still go.
    send_item(REQ_RX, CH_CR, 8'h00);
    send_item(REQ_RX, 8'h00, 8'h00);
    send_item(REQ_RX, 8'hFF, 8'h00);
    send_item(REQ_READ, 8'h00, 8'h00);
    // Release twice: the second finds the line already unlocked.
    send_item(REQ_RELEASE, 8'h00, 8'h00);
    send_item(REQ_RELEASE, 8'hFF, 8'hFF);
    send_item(REQ_UNUSED, 8'hFF, 8'hFF);
    // A stray control byte discards the line and locks it.
    send_item(REQ_RX, 8'h78, 8'h00);
    send_item(REQ_RX, 8'h1F, 8'h00);
    send_item(REQ_READ, 8'h00, 8'h00);
    send_item(REQ_RX, CH_LF, 8'h00);
    send_item(REQ_RELEASE, 8'h00, 8'h00);
    send_item(REQ_RX, CH_NUL, 8'h00);
    send_item(REQ_RELEASE, 8'h00, 8'h00);
    wait_drained();

    // Random part in four idling patterns: none, a slow source, a slow sink,
    // and both slightly slow. The full-line run goes in the fast phase.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1:       begin src_idle_pct = 85; snk_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  snk_stall_pct = 85; end
        default: begin src_idle_pct = 17; snk_stall_pct = 17; end
      endcase
      if (phase == 0) fill_whole_line();
      random_traffic(PHASE_ITEMS);
      wait_drained();
    end

    // Everything owed has come out; give the editor a few more cycles in
    // case it produces something it should not.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (line_sb.errors == 0 && line_sb.awaited.size() == 0) begin
      $display("PASS serial_line_editor");
    end else begin
      if (line_sb.awaited.size() != 0)
        $display("%0t: %0d results never arrived", $time, line_sb.awaited.size());
      $display("FAIL serial_line_editor");
    end
    $finish;
  end

endmodule
